FILE: sv/vgid_pkg.sv
package vgid_pkg;

   localparam int MAX_SIZE_X = 32;
   localparam int MAX_SIZE_Y = 32;
   localparam int MAX_SIZE_Z = 32;

   localparam int IDX_W  = 5;
   localparam int SIZE_W = 6;
   localparam int ADDR_W = $clog2(MAX_SIZE_X * MAX_SIZE_Y * MAX_SIZE_Z);
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_INTERP = 2'd1,
      OP_DIV    = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_Z  = 3'd5;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
   localparam logic [31:0]       INV_RESET  = 32'd65536;

   typedef logic [2:0][31:0] vec_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s,
                                                  input logic [SIZE_W-1:0] maxs);
      logic [SIZE_W-1:0] r;
      if (s < SIZE_W'(2)) r = SIZE_W'(2);
      else if (s > maxs)  r = maxs;
      else                r = s;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] grid_addr(input logic [IDX_W-1:0] x,
                                                   input logic [IDX_W-1:0] y,
                                                   input logic [IDX_W-1:0] z);
      return ADDR_W'(ADDR_W'(z) * ADDR_W'(MAX_SIZE_X * MAX_SIZE_Y))
           + ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_SIZE_X)) + ADDR_W'(x);
   endfunction

endpackage

FILE: sv/vector_grid_interp_divergence.sv
// 3D vector grid (Q16.16) in one single-port synchronous memory, one item at a time.
// An interpolation runs 3 scale multiplies, 8 corner reads and 7 blend steps, a
// divergence 7 neighbor reads and 3 difference multiplies. A write, or a divergence
// outside the grid, goes straight to the result; an interpolation outside the grid
// ends after its scale multiplies and range check. The memory port gives one read
// per cycle. A result may wait in the output register while the next item is accepted.
// Entries must be written before they are read.
module vector_grid_interp_divergence
   import vgid_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  logic [IDX_W-1:0]     req_index_x,
   input  logic [IDX_W-1:0]     req_index_y,
   input  logic [IDX_W-1:0]     req_index_z,
   input  logic signed [31:0]   req_write_x,
   input  logic signed [31:0]   req_write_y,
   input  logic signed [31:0]   req_write_z,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_pos_z,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_out_x,
   output logic signed [31:0]   rsp_out_y,
   output logic signed [31:0]   rsp_out_z,
   output logic signed [31:0]   rsp_divergence,
   output logic                 rsp_out_of_range
);

   typedef enum logic [2:0] {
      S_IDLE, S_SCALE, S_CHECK, S_READ, S_BLEND, S_DIVM, S_DONE
   } state_type;

   state_type state_ff;
   logic [3:0] cnt_ff;

   logic [SIZE_W-1:0] size_ff [3];
   logic [31:0]       inv_ff  [3];
   logic [SIZE_W-1:0] n [3];

   opcode_type        op_ff;
   logic [IDX_W-1:0]  idx_ff [3];
   logic [31:0]       pos_ff [3];
   logic [63:0]       sc_ff  [3];
   vec_type           w_ff   [8];
   logic signed [65:0] prod_ff, prod_in;
   logic signed [51:0] acc_ff, acc_in;
   vec_type           res_v_ff;
   logic [31:0]       res_div_ff;
   logic              res_oor_ff;

   logic              rsp_valid_ff;
   vec_type           rsp_v_ff;
   logic [31:0]       rsp_div_ff;
   logic              rsp_oor_ff;

   vec_type           mem [MAX_SIZE_X * MAX_SIZE_Y * MAX_SIZE_Z];
   vec_type           rdata_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] raddr;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= SIZE_RESET;
         size_ff[1] <= SIZE_RESET;
         size_ff[2] <= SIZE_RESET;
         inv_ff[0]  <= INV_RESET;
         inv_ff[1]  <= INV_RESET;
         inv_ff[2]  <= INV_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_X: size_ff[0] <= csr_wdata[SIZE_W-1:0];
            CSR_SIZE_Y: size_ff[1] <= csr_wdata[SIZE_W-1:0];
            CSR_SIZE_Z: size_ff[2] <= csr_wdata[SIZE_W-1:0];
            CSR_INV_X:  inv_ff[0]  <= csr_wdata;
            CSR_INV_Y:  inv_ff[1]  <= csr_wdata;
            CSR_INV_Z:  inv_ff[2]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign n[0] = eff_size(size_ff[0], SIZE_W'(MAX_SIZE_X));
   assign n[1] = eff_size(size_ff[1], SIZE_W'(MAX_SIZE_Y));
   assign n[2] = eff_size(size_ff[2], SIZE_W'(MAX_SIZE_Z));

   logic accept, req_in_range;
   assign req_ready    = (state_ff == S_IDLE);
   assign accept       = req_valid && req_ready;
   assign req_in_range = (SIZE_W'(req_index_x) < n[0]) && (SIZE_W'(req_index_y) < n[1])
                         && (SIZE_W'(req_index_z) < n[2]);
   assign mem_we = accept && (opcode_type'(req_opcode) == OP_WRITE) && req_in_range;

   // neighbor indices, clamped at the faces
   logic [IDX_W-1:0] prv [3], nxt [3];
   logic             interior [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         prv[a] = (idx_ff[a] == '0) ? idx_ff[a] : idx_ff[a] - IDX_W'(1);
         nxt[a] = ((SIZE_W'(idx_ff[a]) + SIZE_W'(1)) < n[a]) ? idx_ff[a] + IDX_W'(1)
                                                             : idx_ff[a];
         interior[a] = (idx_ff[a] != '0) && (SIZE_W'(idx_ff[a]) != n[a] - SIZE_W'(1));
      end
   end

   logic [IDX_W-1:0] ci [3];
   logic             interp_oor;
   always_comb begin
      interp_oor = 1'b0;
      for (int a = 0; a < 3; a++) begin
         ci[a] = sc_ff[a][32 +: IDX_W];
         if (pos_ff[a][31] || (sc_ff[a][63:32] >= 32'(n[a] - SIZE_W'(1))))
            interp_oor = 1'b1;
      end
   end

   logic [3:0] nreads;
   assign nreads = (op_ff == OP_INTERP) ? 4'd8 : 4'd7;
   assign mem_re = (state_ff == S_READ) && (cnt_ff < nreads);

   always_comb begin
      raddr = grid_addr(idx_ff[0], idx_ff[1], idx_ff[2]);
      if (op_ff == OP_INTERP) begin
         raddr = grid_addr(ci[0] + IDX_W'(cnt_ff[0]), ci[1] + IDX_W'(cnt_ff[1]),
                           ci[2] + IDX_W'(cnt_ff[2]));
      end else begin
         case (cnt_ff)
            4'd1: raddr = grid_addr(prv[0], idx_ff[1], idx_ff[2]);
            4'd2: raddr = grid_addr(nxt[0], idx_ff[1], idx_ff[2]);
            4'd3: raddr = grid_addr(idx_ff[0], prv[1], idx_ff[2]);
            4'd4: raddr = grid_addr(idx_ff[0], nxt[1], idx_ff[2]);
            4'd5: raddr = grid_addr(idx_ff[0], idx_ff[1], prv[2]);
            4'd6: raddr = grid_addr(idx_ff[0], idx_ff[1], nxt[2]);
            default: raddr = grid_addr(idx_ff[0], idx_ff[1], idx_ff[2]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[grid_addr(req_index_x, req_index_y, req_index_z)] <=
         {req_write_z, req_write_y, req_write_x};
      if (mem_re) rdata_ff <= mem[raddr];
   end

   // divergence differences: cur at tap 1, then prev/next pairs per axis
   logic signed [32:0] diff [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic signed [32:0] cv, pv, nv;
         cv = 33'($signed(w_ff[1][a]));
         pv = 33'($signed(w_ff[2 + 2*a][a]));
         nv = 33'($signed(w_ff[3 + 2*a][a]));
         if (idx_ff[a] == '0)                                diff[a] = nv - cv;
         else if (SIZE_W'(idx_ff[a]) == n[a] - SIZE_W'(1))   diff[a] = cv - pv;
         else                                                diff[a] = nv - pv;
      end
   end

   // shared multiplier: position scaling and divergence terms
   logic signed [32:0] mul_a, mul_b;
   logic [1:0]         msel;
   assign msel = cnt_ff[1:0];
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (msel != 2'd3) begin
         mul_b = $signed({1'b0, inv_ff[msel]});
         mul_a = (state_ff == S_DIVM) ? diff[msel] : 33'($signed(pos_ff[msel]));
      end
      prod_in = 66'(mul_a) * 66'(mul_b);
   end

   logic [1:0]         tsel;
   logic signed [65:0] term;
   assign tsel   = cnt_ff[1:0] - 2'd1;
   assign term   = interior[tsel] ? (prod_ff >>> 17) : (prod_ff >>> 16);
   assign acc_in = acc_ff + 52'(term);

   logic [31:0] div_sat;
   always_comb begin
      if (acc_in > 52'sd2147483647)       div_sat = 32'h7fff_ffff;
      else if (acc_in < -52'sd2147483648) div_sat = 32'h8000_0000;
      else                                div_sat = acc_in[31:0];
   end

   // blend lanes: a + floor((b - a) * f / 2^16)
   vec_type     bl_a, bl_b, bl;
   logic [15:0] bl_f;
   always_comb begin
      if (cnt_ff < 4'd4) begin
         bl_a = w_ff[0]; bl_b = w_ff[4]; bl_f = sc_ff[2][31:16];
      end else if (cnt_ff < 4'd6) begin
         bl_a = w_ff[4]; bl_b = w_ff[6]; bl_f = sc_ff[1][31:16];
      end else begin
         bl_a = w_ff[6]; bl_b = w_ff[7]; bl_f = sc_ff[0][31:16];
      end
      for (int c = 0; c < 3; c++) begin
         logic signed [32:0] d;
         logic signed [49:0] bp;
         d  = 33'($signed(bl_b[c])) - 33'($signed(bl_a[c]));
         bp = 50'(d) * 50'($signed({1'b0, bl_f}));
         bl[c] = 32'(50'($signed(bl_a[c])) + (bp >>> 16));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_ff <= prod_in;
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff      <= opcode_type'(req_opcode);
                  idx_ff[0]  <= req_index_x;
                  idx_ff[1]  <= req_index_y;
                  idx_ff[2]  <= req_index_z;
                  pos_ff[0]  <= req_pos_x;
                  pos_ff[1]  <= req_pos_y;
                  pos_ff[2]  <= req_pos_z;
                  res_v_ff   <= '0;
                  res_div_ff <= '0;
                  res_oor_ff <= ((opcode_type'(req_opcode) == OP_WRITE)
                                 || (opcode_type'(req_opcode) == OP_DIV)) && !req_in_range;
                  cnt_ff     <= '0;
                  unique case (opcode_type'(req_opcode))
                     OP_WRITE:  state_ff <= S_DONE;
                     OP_INTERP: state_ff <= S_SCALE;
                     OP_DIV:    state_ff <= req_in_range ? S_READ : S_DONE;
                     default:   state_ff <= S_DONE;
                  endcase
               end
            end
            S_SCALE: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff != '0) begin
                  sc_ff[2] <= prod_ff[63:0];
                  sc_ff[1] <= sc_ff[2];
                  sc_ff[0] <= sc_ff[1];
               end
               if (cnt_ff == 4'd3) state_ff <= S_CHECK;
            end
            S_CHECK: begin
               cnt_ff <= '0;
               if (interp_oor) begin
                  res_oor_ff <= 1'b1;
                  state_ff   <= S_DONE;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               if (cnt_ff != '0) begin
                  for (int i = 0; i < 7; i++) w_ff[i] <= w_ff[i+1];
                  w_ff[7] <= rdata_ff;
               end
               if (cnt_ff == nreads) begin
                  cnt_ff   <= '0;
                  state_ff <= (op_ff == OP_INTERP) ? S_BLEND : S_DIVM;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_BLEND: begin
               cnt_ff <= cnt_ff + 4'd1;
               for (int i = 0; i < 7; i++) w_ff[i] <= w_ff[i+1];
               w_ff[7] <= bl;
               if (cnt_ff == 4'd6) begin
                  res_v_ff <= bl;
                  state_ff <= S_DONE;
               end
            end
            S_DIVM: begin
               cnt_ff <= cnt_ff + 4'd1;
               acc_ff <= (cnt_ff == '0) ? '0 : acc_in;
               if (cnt_ff == 4'd3) begin
                  res_div_ff <= div_sat;
                  state_ff   <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_v_ff     <= res_v_ff;
                  rsp_div_ff   <= res_div_ff;
                  rsp_oor_ff   <= res_oor_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = rsp_v_ff[0];
   assign rsp_out_y        = rsp_v_ff[1];
   assign rsp_out_z        = rsp_v_ff[2];
   assign rsp_divergence   = rsp_div_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_out_x == 0 && rsp_out_y == 0
         && rsp_out_z == 0 && rsp_divergence == 0)
      else $error("out of range result carries data");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divergence != 0 |-> rsp_out_x == 0 && rsp_out_y == 0
         && rsp_out_z == 0)
      else $error("divergence and vector both set");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == S_IDLE && !mem_re)
      else $error("memory write outside idle");

   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> cnt_ff <= nreads)
      else $error("read counter overrun");

endmodule
